>>> sv/tle_pkg.sv
// Shared types, character codes and the erase sequence of the terminal line editor.
package tle_pkg;

   // Character codes.
   localparam logic [7:0] ASCII_LF  = 8'd10;
   localparam logic [7:0] ASCII_CR  = 8'd13;
   localparam logic [7:0] ASCII_BS  = 8'd8;
   localparam logic [7:0] ASCII_DEL = 8'd127;
   localparam logic [7:0] ASCII_ESC = 8'd27;
   localparam logic [7:0] ASCII_LBR = 8'd91;   // '['
   localparam logic [7:0] ASCII_D   = 8'd68;   // 'D'
   localparam logic [7:0] ASCII_SP  = 8'd32;   // ' '

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Beat counter for one command; the erase command is the longest.
   typedef logic [2:0] beat_index_type;
   localparam beat_index_type ERASE_LAST_BEAT = 3'd6;

   // Command kinds.
   typedef logic [1:0] cmd_kind_type;
   localparam cmd_kind_type CMD_CHAR  = 2'd0;   // store a character, maybe end the line
   localparam cmd_kind_type CMD_ERASE = 2'd1;   // echo the erase sequence
   localparam cmd_kind_type CMD_TERM  = 2'd2;   // write the terminator only

   // One classified command.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;     // character to echo and store
      logic [7:0]   pos;    // buffer position of the character
      logic         ends;   // the character completes the line
      logic [7:0]   term;   // terminator position, equal to the line length
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] echo_byte;
      logic       echo_valid;
      logic       store_write;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       line_done;
      logic [7:0] line_length;
      logic       last;
   } rsp_type;

   // Byte of the erase sequence ESC [ D space ESC [ D at a given beat.
   function automatic logic [7:0] erase_byte(input beat_index_type idx);
      logic [7:0] b;
      unique case (idx) inside
         3'd0, 3'd4: b = ASCII_ESC;
         3'd1, 3'd5: b = ASCII_LBR;
         3'd2, 3'd6: b = ASCII_D;
         3'd3:       b = ASCII_SP;
         default:    b = ASCII_ESC;
      endcase
      return b;
   endfunction

endpackage

>>> sv/tle_front.sv
// Front end: accepts received bytes, tracks the line state and classifies each byte.
module tle_front #(
   parameter int MAX_LINE = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [8:0]      csr_write_data,
   input  logic            req_push,
   input  logic [7:0]      req_rx_byte,
   output logic            req_full,
   output logic            q_push,
   output tle_pkg::cmd_type q_data,
   input  logic            q_full
);
   import tle_pkg::*;

   localparam int CapTop     = (MAX_LINE < 256) ? MAX_LINE : 256;
   localparam int ResetCap   = (64 > CapTop) ? CapTop : 64;
   localparam logic [7:0] LimitTop   = 8'(CapTop - 1);
   localparam logic [7:0] LimitReset = 8'(ResetCap - 1);

   logic [7:0] limit_ff, limit_in;
   logic [7:0] chars_ff, chars_in;
   logic       lf_pend_ff, lf_pend_in;
   logic       accept;
   logic [7:0] ch;
   logic [7:0] next_count;
   logic       ends;

   // The character limit is the clamped capacity minus one, worked out at the write.
   always_comb begin
      if (csr_write_data < 9'd2) begin
         limit_in = 8'd1;
      end else if (csr_write_data > 9'(CapTop)) begin
         limit_in = LimitTop;
      end else begin
         limit_in = 8'(csr_write_data - 9'd1);
      end
   end

   assign accept     = req_push & ~q_full;
   assign req_full   = q_full;
   assign ch         = (req_rx_byte == ASCII_CR) ? ASCII_LF : req_rx_byte;
   assign next_count = chars_ff + 8'd1;
   assign ends       = (ch == ASCII_LF) || (next_count >= limit_ff);

   // Classify the byte and work out the next line state.
   always_comb begin
      chars_in        = chars_ff;
      lf_pend_in      = lf_pend_ff;
      q_push          = 1'b0;
      q_data.kind     = CMD_CHAR;
      q_data.ch       = ch;
      q_data.pos      = chars_ff;
      q_data.ends     = ends;
      q_data.term     = next_count;
      if (accept) begin
         if (chars_ff >= limit_ff) begin
            // The capacity shrank below the stored line: close it at once.
            q_push      = 1'b1;
            q_data.kind = CMD_TERM;
            q_data.term = limit_ff;
            chars_in    = 8'd0;
            lf_pend_in  = 1'b0;
         end else if (!lf_pend_ff && req_rx_byte == ASCII_LF) begin
            lf_pend_in = 1'b1;
         end else begin
            lf_pend_in = 1'b0;
            if (ch == ASCII_BS || ch == ASCII_DEL) begin
               if (chars_ff != 8'd0) begin
                  q_push      = 1'b1;
                  q_data.kind = CMD_ERASE;
                  chars_in    = chars_ff - 8'd1;
               end
            end else begin
               q_push   = 1'b1;
               chars_in = ends ? 8'd0 : next_count;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LimitReset;
         chars_ff   <= 8'd0;
         lf_pend_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= limit_in;
         end
         chars_ff   <= chars_in;
         lf_pend_ff <= lf_pend_in;
      end
   end

endmodule

>>> sv/tle_cmd_queue.sv
// Short command queue that decouples the front end from the result back end.
module tle_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tle_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output tle_pkg::cmd_type pop_data,
   output logic             empty
);
   import tle_pkg::*;

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tle_back.sv
// Back end: expands each command into result beats and holds them in the output register.
module tle_back (
   input  logic             clock,
   input  logic             reset,
   input  tle_pkg::cmd_type q_data,
   input  logic             q_empty,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output tle_pkg::rsp_type rsp
);
   import tle_pkg::*;

   beat_index_type beat_ff;
   beat_index_type last_beat;
   logic           out_valid_ff;
   rsp_type        out_ff, beat;
   logic           slot_free, advance, at_last;

   // Index of the final beat of the head command.
   always_comb begin
      unique case (q_data.kind)
         CMD_CHAR:  last_beat = q_data.ends ? 3'd1 : 3'd0;
         CMD_ERASE: last_beat = ERASE_LAST_BEAT;
         CMD_TERM:  last_beat = 3'd0;
         default:   last_beat = 3'd0;
      endcase
   end

   assign at_last   = (beat_ff == last_beat);
   assign slot_free = ~out_valid_ff | rsp_pop;
   assign advance   = slot_free & ~q_empty;
   assign q_pop     = advance & at_last;

   // Build the current beat from the head command.
   always_comb begin
      beat = '0;
      if (q_data.kind == CMD_ERASE) begin
         beat.echo_byte  = erase_byte(beat_ff);
         beat.echo_valid = 1'b1;
         beat.last       = at_last;
      end else if (q_data.kind == CMD_CHAR && beat_ff == 3'd0) begin
         beat.echo_byte   = q_data.ch;
         beat.echo_valid  = 1'b1;
         beat.store_write = 1'b1;
         beat.store_index = q_data.pos;
         beat.store_byte  = q_data.ch;
         beat.last        = ~q_data.ends;
      end else begin
         // Terminator beat.
         beat.store_write = 1'b1;
         beat.store_index = q_data.term;
         beat.line_done   = 1'b1;
         beat.line_length = q_data.term;
         beat.last        = 1'b1;
      end
   end

   // Beat counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         beat_ff      <= at_last ? 3'd0 : beat_ff + 3'd1;
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= beat;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp       = out_ff;

endmodule

>>> sv/terminal_line_editor_unit.sv
// Top level of the terminal line editor.
// Each received byte is classified by the front end and, if it causes results, queued as
// one command in a four-entry queue; the back end sends one result beat per cycle from its
// output register while results are popped. A plain character costs one beat, a character
// that ends the line two, a backspace or delete with stored characters seven, and a dropped
// line feed or a backspace on an empty line none. Sustained input rate is one byte per
// cycle as long as each byte yields at most one beat; otherwise it is set by the back end's
// one beat per cycle, and the queue absorbs short bursts. A byte's first beat comes after
// the queue entry and the output register. The capacity register may only be written while
// the block is idle; its value is clamped to the range 2 to min(MAX_LINE, 256).
module terminal_line_editor_unit #(
   parameter int MAX_LINE = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_echo_valid,
   output logic       rsp_store_write,
   output logic [7:0] rsp_store_index,
   output logic [7:0] rsp_store_byte,
   output logic       rsp_line_done,
   output logic [7:0] rsp_line_length,
   output logic       rsp_last
);
   import tle_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_in, q_out;
   rsp_type rsp;

   // Byte classification and line state.
   tle_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_rx_byte      (req_rx_byte),
      .req_full         (req_full),
      .q_push           (q_push),
      .q_data           (q_in),
      .q_full           (q_full)
   );

   // Command queue.
   tle_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // Result beat generation.
   tle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_out),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_echo_byte   = rsp.echo_byte;
   assign rsp_echo_valid  = rsp.echo_valid;
   assign rsp_store_write = rsp.store_write;
   assign rsp_store_index = rsp.store_index;
   assign rsp_store_byte  = rsp.store_byte;
   assign rsp_line_done   = rsp.line_done;
   assign rsp_line_length = rsp.line_length;
   assign rsp_last        = rsp.last;

endmodule
